>>> hw/rtl/kfb_pkg.sv
package kfb_pkg;

    // Operation codes of an input word.
    typedef enum logic {
        OP_START = 1'b0,
        OP_DATA  = 1'b1
    } op_t;

    // Default largest payload of one frame.
    localparam int MAX_PAYLOAD_DEFAULT = 21;

    // Result queue depth: one word waiting plus the three words of a start.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // ASCII key codes and their bus codes.
    localparam logic [7:0] KEY_DIGIT_LO = 8'h30;
    localparam logic [7:0] KEY_DIGIT_HI = 8'h39;
    localparam logic [7:0] KEY_POUND    = 8'h23;
    localparam logic [7:0] KEY_STAR     = 8'h2A;
    localparam logic [7:0] KEY_F        = 8'h46;
    localparam logic [7:0] KEY_M        = 8'h4D;
    localparam logic [7:0] KEY_P        = 8'h50;
    localparam logic [7:0] KEY_G        = 8'h47;
    localparam logic [7:0] KEY_A        = 8'h41;
    localparam logic [7:0] KEY_D        = 8'h44;
    localparam logic [7:0] KEY_A_OFFSET = 8'h25;
    localparam logic [7:0] CODE_STAR    = 8'h0A;
    localparam logic [7:0] CODE_POUND   = 8'h0B;
    localparam logic [7:0] CODE_F       = 8'h0C;
    localparam logic [7:0] CODE_M       = 8'h0D;
    localparam logic [7:0] CODE_P       = 8'h0E;
    localparam logic [7:0] CODE_G       = 8'h0F;

    // One input word.
    typedef struct packed {
        logic       operation;
        logic [7:0] sequence_req;
        logic [4:0] payload_size;
        logic       translate;
        logic [7:0] data_byte;
    } in_word_t;

    // One result word.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } out_word_t;

    // Maps an ASCII key code to its bus code; unknown keys become zero.
    function automatic logic [7:0] map_key(input logic [7:0] b);
        logic [7:0] r;
        r = 8'h00;
        if (b >= KEY_DIGIT_LO && b <= KEY_DIGIT_HI) r = b - KEY_DIGIT_LO;
        else if (b == KEY_POUND) r = CODE_POUND;
        else if (b == KEY_STAR)  r = CODE_STAR;
        else if (b == KEY_F)     r = CODE_F;
        else if (b == KEY_M)     r = CODE_M;
        else if (b == KEY_P)     r = CODE_P;
        else if (b == KEY_G)     r = CODE_G;
        else if (b >= KEY_A && b <= KEY_D) r = b - KEY_A_OFFSET;
        return r;
    endfunction

endpackage

>>> hw/rtl/keypad_frame_builder_unit.sv
// Channel | Signals                          | Word type
// --------+----------------------------------+------------------------
// source  | src_valid, src_ready, src_word   | kfb_pkg::in_word_t
// result  | dst_valid, dst_ready, dst_word   | kfb_pkg::out_word_t
//
// A payload word's result is registered into the result queue and leaves
// its head once the words ahead are gone. With the result side ready it takes
// one payload word per cycle, save after a frame's last. A start pushes two or
// three words into the four-entry queue, so the source waits while they drain.
// Source ready is high while at most one result word is queued.
// Reset clears the frame state and empties the queue.
module keypad_frame_builder_unit #(
    parameter int MAX_PAYLOAD = kfb_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    output logic               src_ready,
    input  kfb_pkg::in_word_t  src_word,
    output logic               dst_valid,
    input  logic               dst_ready,
    output kfb_pkg::out_word_t dst_word
);

    localparam int DEPTH = kfb_pkg::QUEUE_DEPTH;
    localparam int CW    = kfb_pkg::QUEUE_CNT_W;

    logic       in_frame_reg, in_frame_next;
    logic [4:0] bytes_left_reg, bytes_left_next;
    logic [7:0] running_sum_reg, running_sum_next;
    logic       translate_reg, translate_next;

    kfb_pkg::out_word_t queue_reg [DEPTH];
    kfb_pkg::out_word_t queue_next [DEPTH];
    logic [CW-1:0]      count_reg, count_next;

    kfb_pkg::out_word_t push_word [3];
    logic [1:0]         push_cnt;
    logic               accept;
    logic               pop;
    logic [4:0]         size_clamped;
    logic [7:0]         len_byte;
    logic [7:0]         pay_byte;
    logic [7:0]         sum_start;
    logic [7:0]         sum_data;
    logic [4:0]         left_dec;

    // Handshakes.
    assign src_ready = (count_reg <= CW'(1));
    assign accept    = src_valid && src_ready;
    assign dst_valid = (count_reg != '0);
    assign pop       = dst_valid && dst_ready;
    assign dst_word  = queue_reg[0];

    // Header, payload and checksum bytes.
    always_comb
    begin
        size_clamped = src_word.payload_size;
        if (int'(src_word.payload_size) > MAX_PAYLOAD)
        begin
            size_clamped = 5'(MAX_PAYLOAD);
        end
        len_byte  = {3'b000, size_clamped} + 8'd1;
        sum_start = src_word.sequence_req + len_byte;
        pay_byte  = translate_reg ? kfb_pkg::map_key(src_word.data_byte)
                                  : src_word.data_byte;
        sum_data  = running_sum_reg + pay_byte;
        left_dec  = bytes_left_reg - 5'd1;
    end

    // Frame state and the words pushed by the accepted input word.
    always_comb
    begin
        in_frame_next    = in_frame_reg;
        bytes_left_next  = bytes_left_reg;
        running_sum_next = running_sum_reg;
        translate_next   = translate_reg;
        push_cnt         = 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            push_word[i] = '{out_byte: 8'h00, frame_end: 1'b0};
        end
        if (accept)
        begin
            if (src_word.operation == kfb_pkg::OP_START)
            begin
                translate_next   = src_word.translate;
                running_sum_next = sum_start;
                bytes_left_next  = size_clamped;
                in_frame_next    = (size_clamped != 5'd0);
                push_word[0]     = '{out_byte: src_word.sequence_req, frame_end: 1'b0};
                push_word[1]     = '{out_byte: len_byte, frame_end: 1'b0};
                push_word[2]     = '{out_byte: 8'h00 - sum_start, frame_end: 1'b1};
                push_cnt         = (size_clamped == 5'd0) ? 2'd3 : 2'd2;
            end
            else if (in_frame_reg && bytes_left_reg != 5'd0)
            begin
                running_sum_next = sum_data;
                bytes_left_next  = left_dec;
                in_frame_next    = (left_dec != 5'd0);
                push_word[0]     = '{out_byte: pay_byte, frame_end: 1'b0};
                push_word[1]     = '{out_byte: 8'h00 - sum_data, frame_end: 1'b1};
                push_cnt         = (left_dec == 5'd0) ? 2'd2 : 2'd1;
            end
        end
    end

    // Result queue: drop the head on a pop, append the pushed words behind.
    always_comb
    begin
        int keep;
        int src;
        int k;
        keep = int'(count_reg) - (pop ? 1 : 0);
        for (int i = 0; i < DEPTH; i++)
        begin
            src = i + (pop ? 1 : 0);
            k   = i - keep;
            queue_next[i] = queue_reg[i];
            if (i < keep)
            begin
                queue_next[i] = queue_reg[src[kfb_pkg::QUEUE_IDX_W-1:0]];
            end
            else if (k >= 0 && k < int'(push_cnt))
            begin
                queue_next[i] = push_word[k[1:0]];
            end
        end
        count_next = CW'(keep + int'(push_cnt));
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg    <= 1'b0;
            bytes_left_reg  <= 5'd0;
            running_sum_reg <= 8'd0;
            translate_reg   <= 1'b0;
            count_reg       <= '0;
        end
        else
        begin
            in_frame_reg    <= in_frame_next;
            bytes_left_reg  <= bytes_left_next;
            running_sum_reg <= running_sum_next;
            translate_reg   <= translate_next;
            count_reg       <= count_next;
        end
    end

    // Queue payload registers.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            queue_reg[i] <= queue_next[i];
        end
    end

    // The queue never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(DEPTH))
        else $error("result queue overflow");

    // An open frame always has payload bytes left to take.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg == (bytes_left_reg != 5'd0))
        else $error("frame state and byte count disagree");

    // A start always leaves a word at the queue head.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && src_word.operation == kfb_pkg::OP_START |=> dst_valid)
        else $error("start produced no result word");

    // A payload word taken outside a frame pushes nothing; only a pop moves
    // the queue count.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && src_word.operation == kfb_pkg::OP_DATA && !in_frame_reg
        |=> count_reg == $past(count_reg) - CW'($past(pop)))
        else $error("payload outside a frame changed the queue");

endmodule

>>> bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLAMP_SIZE        = kfb_pkg::MAX_PAYLOAD_DEFAULT;
    localparam int RANDOM_WORDS      = 320;
    localparam int CYCLE_LIMIT       = 300000;
    localparam int TAIL_CYCLES       = 8;
    localparam int LONG_STALL_CYCLES = 80;
    localparam int CALM_TAIL         = 60;

    // A pending source word, optionally held back until the result side is empty.
    typedef struct {
        kfb_pkg::in_word_t word;
        bit                wait_drain;
    } src_item_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               src_valid = 1'b0;
    logic               src_ready;
    kfb_pkg::in_word_t  src_word  = '0;
    logic               dst_valid;
    logic               dst_ready = 1'b0;
    kfb_pkg::out_word_t dst_word;

    src_item_t          pending_words[$];
    kfb_pkg::out_word_t frame_bytes_due[$];

    int   error_count = 0;
    int   cycle_count = 0;
    int   words_taken = 0;
    int   src_gap     = 0;
    int   dst_gap     = 0;
    logic src_fire    = 1'b0;
    logic long_stall  = 1'b0;

    // Frame state mirrored from the block.
    logic       frame_open  = 1'b0;
    logic [4:0] bytes_to_go = '0;
    logic [7:0] frame_sum   = '0;
    logic       key_mode    = 1'b0;

    keypad_frame_builder_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_word  (src_word),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_word  (dst_word)
    );

    // Free-running clock, 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Bus code of an ASCII key; anything that is not a key maps to zero.
    function automatic logic [7:0] key_to_bus(input logic [7:0] key);
        if (key >= kfb_pkg::KEY_DIGIT_LO && key <= kfb_pkg::KEY_DIGIT_HI)
            return key - kfb_pkg::KEY_DIGIT_LO;
        if (key >= kfb_pkg::KEY_A && key <= kfb_pkg::KEY_D)
            return key - kfb_pkg::KEY_A_OFFSET;
        case (key)
            kfb_pkg::KEY_STAR:  return kfb_pkg::CODE_STAR;
            kfb_pkg::KEY_POUND: return kfb_pkg::CODE_POUND;
            kfb_pkg::KEY_F:     return kfb_pkg::CODE_F;
            kfb_pkg::KEY_M:     return kfb_pkg::CODE_M;
            kfb_pkg::KEY_P:     return kfb_pkg::CODE_P;
            kfb_pkg::KEY_G:     return kfb_pkg::CODE_G;
            default:            return 8'h00;
        endcase
    endfunction

    task automatic push_frame_byte(input logic [7:0] value, input logic last);
        kfb_pkg::out_word_t w;
        w.out_byte  = value;
        w.frame_end = last;
        frame_bytes_due.push_back(w);
    endtask

    // The checksum makes all bytes of the frame sum to zero.
    task automatic close_frame();
        push_frame_byte(8'h00 - frame_sum, 1'b1);
        frame_open  = 1'b0;
        bytes_to_go = '0;
    endtask

    // Works out the frame bytes that one accepted source word produces.
    task automatic predict_frame_bytes(input kfb_pkg::in_word_t w);
        logic [4:0] size;
        logic [7:0] len_byte;
        logic [7:0] b;
        if (w.operation == kfb_pkg::OP_START)
        begin
            size     = (w.payload_size > CLAMP_SIZE) ? 5'(CLAMP_SIZE) : w.payload_size;
            len_byte = 8'(size) + 8'd1;
            key_mode = w.translate;
            push_frame_byte(w.sequence_req, 1'b0);
            push_frame_byte(len_byte, 1'b0);
            frame_sum   = w.sequence_req + len_byte;
            bytes_to_go = size;
            frame_open  = 1'b1;
            if (size == 0)
                close_frame();
        end
        else if (frame_open && bytes_to_go != 0)
        begin
            b = key_mode ? key_to_bus(w.data_byte) : w.data_byte;
            push_frame_byte(b, 1'b0);
            frame_sum   = frame_sum + b;
            bytes_to_go = bytes_to_go - 1'b1;
            if (bytes_to_go == 0)
                close_frame();
        end
    endtask

    // Unused fields of each word carry random bits.
    task automatic add_start(input logic [7:0] seq, input logic [4:0] size,
                             input logic tr, input bit drain);
        src_item_t it;
        it.word              = kfb_pkg::in_word_t'($urandom);
        it.word.operation    = kfb_pkg::OP_START;
        it.word.sequence_req = seq;
        it.word.payload_size = size;
        it.word.translate    = tr;
        it.wait_drain        = drain;
        pending_words.push_back(it);
    endtask

    task automatic add_data(input logic [7:0] value);
        src_item_t it;
        it.word           = kfb_pkg::in_word_t'($urandom);
        it.word.operation = kfb_pkg::OP_DATA;
        it.word.data_byte = value;
        it.wait_drain     = 1'b0;
        pending_words.push_back(it);
    endtask

    // In translate mode most payload bytes are real key codes.
    function automatic logic [7:0] payload_pick(input logic tr);
        int idx;
        if (!tr || $urandom_range(0, 3) == 0)
            return 8'($urandom);
        idx = $urandom_range(0, 19);
        if (idx < 10)
            return kfb_pkg::KEY_DIGIT_LO + 8'(idx);
        if (idx < 14)
            return kfb_pkg::KEY_A + 8'(idx - 10);
        case (idx)
            14:      return kfb_pkg::KEY_STAR;
            15:      return kfb_pkg::KEY_POUND;
            16:      return kfb_pkg::KEY_F;
            17:      return kfb_pkg::KEY_M;
            18:      return kfb_pkg::KEY_P;
            default: return kfb_pkg::KEY_G;
        endcase
    endfunction

    // No idling near the end of the run, and in some windows along the way.
    function automatic bit calm_now();
        return pending_words.size() < CALM_TAIL || ((pending_words.size() / 45) % 4) == 2;
    endfunction

    // Source driver: offers the next pending word at the falling edge.
    always @(negedge clk)
    begin
        if (!rst_n)
            src_valid <= 1'b0;
        else if (src_valid && !src_fire)
            src_valid <= 1'b1;
        else if (src_gap > 0)
        begin
            src_gap--;
            src_valid <= 1'b0;
        end
        else if (pending_words.size() == 0 ||
                 (pending_words[0].wait_drain && frame_bytes_due.size() != 0))
            src_valid <= 1'b0;
        else
        begin
            src_word  <= pending_words[0].word;
            src_valid <= 1'b1;
            pending_words.pop_front();
            if (!calm_now() && $urandom_range(0, 4) == 0)
                src_gap = $urandom_range(1, 11);
        end
    end

    // Result side ready, with random stall bursts and the long hold-off.
    always @(negedge clk)
    begin
        if (!rst_n || long_stall)
            dst_ready <= 1'b0;
        else if (dst_gap > 0)
        begin
            dst_gap--;
            dst_ready <= 1'b0;
        end
        else if (!calm_now() && $urandom_range(0, 5) == 0)
        begin
            dst_gap = $urandom_range(0, 10);
            dst_ready <= 1'b0;
        end
        else
            dst_ready <= 1'b1;
    end

    // Hold the result side off long enough for the block to stall its input.
    initial
    begin
        wait (words_taken >= 40);
        @(posedge clk);
        long_stall <= 1'b1;
        repeat (LONG_STALL_CYCLES) @(posedge clk);
        long_stall <= 1'b0;
        wait (words_taken >= 220);
        @(posedge clk);
        long_stall <= 1'b1;
        repeat (LONG_STALL_CYCLES) @(posedge clk);
        long_stall <= 1'b0;
    end

    // Monitor: predicts on each accepted source word and checks each result word.
    always @(posedge clk)
    begin
        kfb_pkg::out_word_t due_word;
        if (!rst_n)
            src_fire <= 1'b0;
        else
        begin
            src_fire <= src_valid && src_ready;
            if (src_valid && src_ready)
            begin
                predict_frame_bytes(src_word);
                words_taken++;
            end
            if (dst_valid && dst_ready)
            begin
                if (frame_bytes_due.size() == 0)
                    report_mismatch($sformatf("unexpected word byte=%h end=%b",
                                              dst_word.out_byte, dst_word.frame_end));
                else
                begin
                    due_word = frame_bytes_due.pop_front();
                    if (dst_word.out_byte !== due_word.out_byte)
                        report_mismatch($sformatf("out_byte %h, expected %h",
                                                  dst_word.out_byte, due_word.out_byte));
                    if (dst_word.frame_end !== due_word.frame_end)
                        report_mismatch($sformatf("frame_end %b, expected %b",
                                                  dst_word.frame_end, due_word.frame_end));
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int  counted;
        int  next_drain;
        int  size;
        int  eff;
        int  n_data;
        int  kind;
        int  r;
        bit  tr;

        // Directed words: payload outside a frame, empty frame, clamped size, both ends
        // of each key range and every other key code, a start inside an open frame.
        add_data(8'hFF);
        add_start(8'h00, 5'd0, 1'b0, 1'b0);
        add_data(8'h00);
        add_start(8'hFF, 5'd31, 1'b1, 1'b1);
        add_data(kfb_pkg::KEY_DIGIT_LO);
        add_data(kfb_pkg::KEY_DIGIT_HI);
        add_data(kfb_pkg::KEY_STAR);
        add_data(kfb_pkg::KEY_POUND);
        add_data(kfb_pkg::KEY_F);
        add_data(kfb_pkg::KEY_M);
        add_data(kfb_pkg::KEY_P);
        add_data(kfb_pkg::KEY_G);
        add_data(kfb_pkg::KEY_A);
        add_data(kfb_pkg::KEY_D);
        add_data(8'h42);
        add_data(8'h45);
        add_data(8'hFF);
        add_start(8'hA5, 5'd2, 1'b0, 1'b0);
        add_data(8'h00);
        add_data(8'hFF);
        add_data(8'h5A);
        add_start(8'h80, 5'd1, 1'b1, 1'b0);
        add_data(8'h2F);
        add_start(8'h3C, 5'd22, 1'b0, 1'b1);

        // Random frames, mostly complete, some cut short or followed by stray words.
        counted    = 0;
        next_drain = 120;
        while (counted < RANDOM_WORDS)
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
                size = 0;
            else if (r <= 14)
                size = $urandom_range(1, 6);
            else if (r <= 17)
                size = $urandom_range(7, CLAMP_SIZE);
            else
                size = $urandom_range(CLAMP_SIZE + 1, 31);
            tr = $urandom_range(0, 1);
            add_start(8'($urandom), 5'(size), tr, counted >= next_drain);
            if (counted >= next_drain)
                next_drain += 160;
            counted++;
            eff    = (size > CLAMP_SIZE) ? CLAMP_SIZE : size;
            kind   = $urandom_range(0, 9);
            n_data = (kind == 0 && eff > 0) ? $urandom_range(0, eff - 1) : eff;
            repeat (n_data) add_data(payload_pick(tr));
            counted += n_data;
            if (kind == 1)
                repeat ($urandom_range(1, 3)) add_data(8'($urandom));
        end

        repeat (4) @(posedge clk);
        #3 rst_n = 1'b1;

        while (pending_words.size() != 0 || src_valid || frame_bytes_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (frame_bytes_due.size() != 0)
            report_mismatch($sformatf("%0d result words never arrived",
                                      frame_bytes_due.size()));

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/kfb_pkg.sv
hw/rtl/keypad_frame_builder_unit.sv
bench/testbench.sv
